### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the curve point generator.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When pre holds, post holds at the next clock edge.
`define ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/pcpg_pkg.sv
// Package of the parametric curve point generator: fixed-point widths,
// curve codes, register indexes, CORDIC table and stage types. No dependencies.
package pcpg_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int CORDIC_BITS = 30;
  localparam int N_ITER      = 30;
  localparam int CORDIC_W    = CORDIC_BITS + 4;
  localparam int Q_W         = FRAC_BITS + 2;
  localparam int SQ_W        = FRAC_BITS + 4;
  localparam int T_W         = FRAC_BITS + 6;
  localparam int TERM_W      = FRAC_BITS + 9;
  localparam int PROD_W      = TERM_W + 8;
  localparam int TOT_W       = PROD_W + 1;
  localparam int STEP_W      = 9;
  localparam int COORD_W     = 12;
  localparam int PIX_W       = 14;

  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  // 2^28 = 25 * 10737418 + 6, so k * 2^32 / 400 splits into a product and a small rest.
  localparam logic [23:0] PH400_MUL   = 24'd10737418;
  localparam logic [11:0] DIV25_RECIP = 12'd2622;
  localparam logic [8:0]  STEPS_ASTROID = 9'd400;

  localparam logic [31:0] ATAN_TAB [0:N_ITER-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef enum logic [1:0] {
    CURVE_ASTROID = 2'd0,
    CURVE_CYCLOID = 2'd1,
    CURVE_EPI     = 2'd2,
    CURVE_HYPO    = 2'd3
  } curve_t;

  localparam logic [1:0] REG_CURVE    = 2'd0;
  localparam logic [1:0] REG_CENTER_X = 2'd1;
  localparam logic [1:0] REG_CENTER_Y = 2'd2;

  typedef struct packed {
    curve_t         sel;
    logic           past;
    logic [T_W-1:0] t;
  } ctl_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
    logic                       flip;
  } cord_t;

  typedef struct packed {
    ctl_t  ctl;
    cord_t a;
    cord_t b;
  } cstage_t;

  // Folds the phase into the right half-plane and loads the CORDIC start vector.
  function automatic cord_t cord_init(logic [31:0] ph);
    cord_t       r;
    logic [31:0] p;
    r.flip = ph[31] ^ ph[30];
    p      = ph ^ {r.flip, 31'b0};
    r.x    = CORDIC_W'(CORDIC_GAIN);
    r.y    = '0;
    r.z    = {{(CORDIC_W-32){p[31]}}, p};
    return r;
  endfunction

  function automatic cord_t cord_iter(cord_t c, int unsigned i);
    cord_t                      r;
    logic signed [CORDIC_W-1:0] at;
    at = CORDIC_W'(ATAN_TAB[i]);
    r  = c;
    if (!c.z[CORDIC_W-1]) begin
      r.x = c.x - (c.y >>> i);
      r.y = c.y + (c.x >>> i);
      r.z = c.z - at;
    end else begin
      r.x = c.x + (c.y >>> i);
      r.y = c.y - (c.x >>> i);
      r.z = c.z + at;
    end
    return r;
  endfunction

endpackage

### rtl/core/parametric_curve_point_generator.sv
// Parametric curve point generator: step index in, one screen point out.
// Uses pcpg_pkg and assert_macros.svh.
//
// Input channel in_*: one step index k per transaction. Output channel out_*:
// pixel_x, pixel_y and the past_end flag of the selected curve, one transaction
// per input transaction, in order. Configuration port cfg_*: index 0 selects
// the curve (astroid, cycloid, Huygens epicycloid, hypocycloid), indexes 1 and
// 2 set the center; index 3 is ignored. Write it only while the block is idle.
// The datapath is a 41-stage pipeline: phase generation (5 stages), two 30-step
// CORDIC rotators side by side (one per stage), then curve terms, scaling and
// truncation (6 stages). One item can enter in every cycle unless every stage
// holds an item and out_tready is low. The ready chain lets a bubble anywhere
// in the pipe take a new item while a finished result waits on out_tready; the
// pipe fills up and in_tready falls only when every stage holds an item.
// Reset empties the pipe and loads curve 0 with center (200, 100).
module parametric_curve_point_generator
  import pcpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [8:0] step_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [13:0] pixel_x, [27:14] pixel_y
  output logic        out_tuser,  // [0] past_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

`include "assert_macros.svh"

  localparam int ST_CORD0 = 4;
  localparam int ST_FIN   = ST_CORD0 + N_ITER + 1;
  localparam int ST_TERM  = ST_FIN + 1;
  localparam int ST_CUBE  = ST_TERM + 1;
  localparam int ST_SCALE = ST_CUBE + 1;
  localparam int ST_SUM   = ST_SCALE + 1;
  localparam int ST_OUT   = ST_SUM + 1;
  localparam int NSTG     = ST_OUT + 1;

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [SQ_W-1:0]   sq_t;
  typedef logic signed [TERM_W-1:0] term_t;

  // Configuration registers.
  curve_t             curve_r;
  logic [COORD_W-1:0] center_x_r, center_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_r    <= CURVE_ASTROID;
      center_x_r <= COORD_W'(200);
      center_y_r <= COORD_W'(100);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CURVE:    curve_r    <= curve_t'(cfg_data[1:0]);
        REG_CENTER_X: center_x_r <= cfg_data;
        REG_CENTER_Y: center_y_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Valid bits and the load chain: a stage loads when it is empty or its
  // successor loads in the same cycle.
  logic [NSTG-1:0] v_r, ld;

  always_comb begin
    ld[NSTG-1] = !v_r[NSTG-1] || out_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      ld[i] = !v_r[i] || ld[i+1];
    end
  end

  assign in_tready = ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_tvalid;
      for (int i = 1; i < NSTG; i++) begin
        if (ld[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // Stage 0: step index, 6k and k times the number of turns.
  logic [STEP_W-1:0] k_a_r;
  logic [11:0]       k6_a_r, k6_nxt;
  logic [7:0]        km_a_r, km_nxt;
  curve_t            sel_a_r;

  always_comb begin
    k6_nxt = {1'b0, in_tdata[8:0], 2'b0} + {2'b0, in_tdata[8:0], 1'b0};
    case (curve_r)
      CURVE_CYCLOID: km_nxt = 8'({in_tdata[8:0], 1'b0} + {1'b0, in_tdata[8:0]});
      CURVE_EPI:     km_nxt = {in_tdata[6:0], 1'b0};
      default:       km_nxt = in_tdata[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      k_a_r   <= in_tdata[STEP_W-1:0];
      k6_a_r  <= k6_nxt;
      km_a_r  <= km_nxt;
      sel_a_r <= curve_r;
    end
  end

  // Stage 1: the products behind the phase and the cycloid angle term.
  logic [31:0] pa_b_r;
  logic [6:0]  pq_b_r;
  logic [7:0]  km_b_r;
  ctl_t        ctl_b_r, ctl_b_nxt;
  logic [32:0] pa_full;
  logic [23:0] pq_full;
  logic [43:0] t_full;

  always_comb begin
    pa_full       = k_a_r * PH400_MUL;
    pq_full       = k6_a_r * DIV25_RECIP;
    t_full        = k6_a_r * PI_Q30;
    ctl_b_nxt.sel = sel_a_r;
    ctl_b_nxt.past = (sel_a_r == CURVE_ASTROID) ? (k_a_r >= STEPS_ASTROID) : k_a_r[8];
    ctl_b_nxt.t   = t_full[8 + CORDIC_BITS - FRAC_BITS +: T_W];
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      pa_b_r  <= pa_full[31:0];
      pq_b_r  <= pq_full[22:16];
      km_b_r  <= km_a_r;
      ctl_b_r <= ctl_b_nxt;
    end
  end

  // Stage 2: phase of the base angle, 2^32 units per turn.
  logic [31:0] ph_c_r, ph_c_nxt;
  ctl_t        ctl_c_r;

  always_comb begin
    if (ctl_b_r.sel == CURVE_ASTROID) ph_c_nxt = pa_b_r + {25'b0, pq_b_r};
    else                              ph_c_nxt = {km_b_r, 24'b0};
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      ph_c_r  <= ph_c_nxt;
      ctl_c_r <= ctl_b_r;
    end
  end

  // Stage 3: phase of the doubled or tripled angle.
  logic [31:0] ph_d_r, ph2_d_r, ph2_nxt;
  ctl_t        ctl_d_r;

  always_comb begin
    if (ctl_c_r.sel == CURVE_EPI) ph2_nxt = ph_c_r + {ph_c_r[30:0], 1'b0};
    else                          ph2_nxt = {ph_c_r[30:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      ph_d_r  <= ph_c_r;
      ph2_d_r <= ph2_nxt;
      ctl_d_r <= ctl_c_r;
    end
  end

  // CORDIC: entry stage, then one rotation step per stage for both angles.
  cstage_t cord_r   [0:N_ITER];
  cstage_t cord_nxt [0:N_ITER];

  always_comb begin
    cord_nxt[0].ctl = ctl_d_r;
    cord_nxt[0].a   = cord_init(ph_d_r);
    cord_nxt[0].b   = cord_init(ph2_d_r);
  end

  always_ff @(posedge clk) begin
    if (ld[ST_CORD0]) cord_r[0] <= cord_nxt[0];
  end

  for (genvar i = 0; i < N_ITER; i++) begin : g_cord
    always_comb begin
      cord_nxt[i+1].ctl = cord_r[i].ctl;
      cord_nxt[i+1].a   = cord_iter(cord_r[i].a, i);
      cord_nxt[i+1].b   = cord_iter(cord_r[i].b, i);
    end

    always_ff @(posedge clk) begin
      if (ld[ST_CORD0+1+i]) cord_r[i+1] <= cord_nxt[i+1];
    end
  end

  // Undo the half-turn fold and floor to FRAC_BITS fraction bits.
  q_t   c_f_r, s_f_r, c2_f_r, s2_f_r;
  ctl_t ctl_f_r;
  logic signed [CORDIC_W-1:0] xa, ya, xb, yb, xa_s, ya_s, xb_s, yb_s;

  always_comb begin
    xa   = cord_r[N_ITER].a.flip ? -cord_r[N_ITER].a.x : cord_r[N_ITER].a.x;
    ya   = cord_r[N_ITER].a.flip ? -cord_r[N_ITER].a.y : cord_r[N_ITER].a.y;
    xb   = cord_r[N_ITER].b.flip ? -cord_r[N_ITER].b.x : cord_r[N_ITER].b.x;
    yb   = cord_r[N_ITER].b.flip ? -cord_r[N_ITER].b.y : cord_r[N_ITER].b.y;
    xa_s = xa >>> (CORDIC_BITS - FRAC_BITS);
    ya_s = ya >>> (CORDIC_BITS - FRAC_BITS);
    xb_s = xb >>> (CORDIC_BITS - FRAC_BITS);
    yb_s = yb >>> (CORDIC_BITS - FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (ld[ST_FIN]) begin
      c_f_r   <= xa_s[Q_W-1:0];
      s_f_r   <= ya_s[Q_W-1:0];
      c2_f_r  <= xb_s[Q_W-1:0];
      s2_f_r  <= yb_s[Q_W-1:0];
      ctl_f_r <= cord_r[N_ITER].ctl;
    end
  end

  // Curve terms; the astroid takes its squares here and its cubes next.
  sq_t   cc_g_r, ss_g_r;
  q_t    c_g_r, s_g_r;
  term_t xi_g_r, yi_g_r, xi_nxt, yi_nxt;
  ctl_t  ctl_g_r;
  logic signed [2*Q_W-1:0] cc_full, ss_full, cc_s, ss_s;
  term_t c_e, s_e, c2_e, s2_e;

  always_comb begin
    cc_full = c_f_r * c_f_r;
    ss_full = s_f_r * s_f_r;
    cc_s    = cc_full >>> FRAC_BITS;
    ss_s    = ss_full >>> FRAC_BITS;
    c_e     = TERM_W'(c_f_r);
    s_e     = TERM_W'(s_f_r);
    c2_e    = TERM_W'(c2_f_r);
    s2_e    = TERM_W'(s2_f_r);
    case (ctl_f_r.sel)
      CURVE_CYCLOID: begin
        xi_nxt = (term_t'(1) <<< FRAC_BITS) - c_e;
        yi_nxt = term_t'({1'b0, ctl_f_r.t}) - s_e;
      end
      CURVE_EPI: begin
        xi_nxt = c_e + (c_e <<< 1) - c2_e;
        yi_nxt = s_e + (s_e <<< 1) - s2_e;
      end
      CURVE_HYPO: begin
        xi_nxt = (c_e <<< 1) + c2_e;
        yi_nxt = (s_e <<< 1) - s2_e;
      end
      default: begin
        xi_nxt = c_e;
        yi_nxt = s_e;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[ST_TERM]) begin
      cc_g_r  <= cc_s[SQ_W-1:0];
      ss_g_r  <= ss_s[SQ_W-1:0];
      c_g_r   <= c_f_r;
      s_g_r   <= s_f_r;
      xi_g_r  <= xi_nxt;
      yi_g_r  <= yi_nxt;
      ctl_g_r <= ctl_f_r;
    end
  end

  term_t xi_h_r, yi_h_r, xi_h_nxt, yi_h_nxt;
  ctl_t  ctl_h_r;
  logic signed [SQ_W+Q_W-1:0] ccc_full, sss_full, ccc_s, sss_s;

  always_comb begin
    ccc_full = cc_g_r * c_g_r;
    sss_full = ss_g_r * s_g_r;
    ccc_s    = ccc_full >>> FRAC_BITS;
    sss_s    = sss_full >>> FRAC_BITS;
    if (ctl_g_r.sel == CURVE_ASTROID) begin
      xi_h_nxt = ccc_s[TERM_W-1:0];
      yi_h_nxt = sss_s[TERM_W-1:0];
    end else begin
      xi_h_nxt = xi_g_r;
      yi_h_nxt = yi_g_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_CUBE]) begin
      xi_h_r  <= xi_h_nxt;
      yi_h_r  <= yi_h_nxt;
      ctl_h_r <= ctl_g_r;
    end
  end

  // Scale: the multiplier folds the curve scale with the term's own factor;
  // the half factor of 1.5 is carried as one more fraction bit.
  logic signed [PROD_W-1:0] px_i_r, py_i_r, px_nxt, py_nxt;
  logic signed [7:0]        mult;
  ctl_t                     ctl_i_r;

  always_comb begin
    case (ctl_h_r.sel)
      CURVE_CYCLOID: mult = 8'sd12;
      CURVE_EPI:     mult = 8'sd16;
      CURVE_HYPO:    mult = 8'sd45;
      default:       mult = 8'sd80;
    endcase
    px_nxt = xi_h_r * mult;
    py_nxt = yi_h_r * mult;
  end

  always_ff @(posedge clk) begin
    if (ld[ST_SCALE]) begin
      px_i_r  <= px_nxt;
      py_i_r  <= py_nxt;
      ctl_i_r <= ctl_h_r;
    end
  end

  // Add the center at the same binary point.
  logic signed [TOT_W-1:0] tx_j_r, ty_j_r, tx_nxt, ty_nxt, cx_e, cy_e;
  logic                    sh17_j_r, sh17_nxt, past_j_r;

  always_comb begin
    sh17_nxt = (ctl_i_r.sel == CURVE_CYCLOID) || (ctl_i_r.sel == CURVE_HYPO);
    cx_e     = TOT_W'({1'b0, center_x_r});
    cy_e     = TOT_W'({1'b0, center_y_r});
    if (sh17_nxt) begin
      tx_nxt = TOT_W'(px_i_r) + (cx_e <<< (FRAC_BITS + 1));
      ty_nxt = TOT_W'(py_i_r) + (cy_e <<< (FRAC_BITS + 1));
    end else begin
      tx_nxt = TOT_W'(px_i_r) + (cx_e <<< FRAC_BITS);
      ty_nxt = TOT_W'(py_i_r) + (cy_e <<< FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_SUM]) begin
      tx_j_r   <= tx_nxt;
      ty_j_r   <= ty_nxt;
      sh17_j_r <= sh17_nxt;
      past_j_r <= ctl_i_r.past;
    end
  end

  // Truncate toward zero: bias negative totals before the arithmetic shift.
  logic [PIX_W-1:0]        pix_x_r, pix_y_r;
  logic                    past_k_r;
  logic signed [TOT_W-1:0] bias, bx, by, qx, qy;

  always_comb begin
    bias = sh17_j_r ? TOT_W'((1 << (FRAC_BITS + 1)) - 1) : TOT_W'((1 << FRAC_BITS) - 1);
    bx   = tx_j_r[TOT_W-1] ? tx_j_r + bias : tx_j_r;
    by   = ty_j_r[TOT_W-1] ? ty_j_r + bias : ty_j_r;
    qx   = sh17_j_r ? (bx >>> (FRAC_BITS + 1)) : (bx >>> FRAC_BITS);
    qy   = sh17_j_r ? (by >>> (FRAC_BITS + 1)) : (by >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (ld[ST_OUT]) begin
      pix_x_r  <= qx[PIX_W-1:0];
      pix_y_r  <= qy[PIX_W-1:0];
      past_k_r <= past_j_r;
    end
  end

  assign out_tvalid = v_r[ST_OUT];
  assign out_tdata  = {4'b0, pix_y_r, pix_x_r};
  assign out_tuser  = past_k_r;

  // A refused input transaction means the pipe has no bubble left.
  `ASSERT_ALWAYS(a_full_when_blocked, in_tready || (&v_r), "input refused with a free stage")
  `ASSERT_NEXT(a_enter, in_tvalid && in_tready, v_r[0], "accepted item lost at entry")
  // After the last rotation step the residual angle is below 256 table units in magnitude.
  `ASSERT_ALWAYS(a_cordic_converged,
    !v_r[ST_FIN-1] || (cord_r[N_ITER].a.z > -256 && cord_r[N_ITER].a.z < 256),
    "CORDIC residual angle out of range")

endmodule
